[hw/rtl/cfmp_pkg.sv]
// ----------------------------------------------------------------------------
// cfmp_pkg
// Shared types, constants and helper functions for the cron field mask parser.
// ----------------------------------------------------------------------------
package cfmp_pkg;

  localparam int MAX_POSITIONS_DEF = 60;
  localparam int FILL_LIMIT_DEF    = 1024;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int MAP_W      = 60;
  localparam int NUM_W      = 12;
  localparam int VAL_W      = 13;
  localparam int FS_W       = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [NUM_W-1:0] SAT_MAX = 12'd4095;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_TABLE   = 2'd2;

  localparam logic [1:0] TABLE_NONE  = 2'd0;
  localparam logic [1:0] TABLE_MONTH = 2'd1;
  localparam logic [1:0] TABLE_DAY   = 2'd2;

  localparam logic [FS_W-1:0] FIELD_SIZE_RST = 6'd60;

  localparam logic CMD_FILL = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [23:0] MONTH_NAMES [12] = '{
    "jan", "feb", "mar", "apr", "may", "jun",
    "jul", "aug", "sep", "oct", "nov", "dec"
  };
  localparam logic [23:0] DAY_NAMES [7] = '{
    "sun", "mon", "tue", "wed", "thu", "fri", "sat"
  };

  typedef struct packed {
    logic              kind;
    logic              err;
    logic [NUM_W-1:0]  start;
    logic [NUM_W-1:0]  stop;
    logic [NUM_W-1:0]  step;
  } cmd_t;

  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } name_hit_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  function automatic logic [NUM_W-1:0] sat_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [7:0] c);
    logic [15:0] v;
    v = 16'({acc, 3'b000}) + 16'({acc, 1'b0}) + 16'(c - CH_ZERO);
    return (v > 16'(SAT_MAX)) ? SAT_MAX : v[NUM_W-1:0];
  endfunction

  function automatic name_hit_t name_lookup(input logic [1:0] tab,
                                            input logic [23:0] key);
    name_hit_t hit;
    hit = '0;
    if (tab == TABLE_MONTH) begin
      for (int i = 0; i < 12; i++) begin
        if (!hit.found && MONTH_NAMES[i] == key) begin
          hit.found = 1'b1;
          hit.idx   = 4'(i);
        end
      end
    end else begin
      for (int i = 0; i < 7; i++) begin
        if (!hit.found && DAY_NAMES[i] == key) begin
          hit.found = 1'b1;
          hit.idx   = 4'(i);
        end
      end
    end
    return hit;
  endfunction

endpackage

[hw/rtl/cron_field_mask_parser_unit.sv]
// ----------------------------------------------------------------------------
// cron_field_mask_parser_unit
// Parses one cron time field, one character per transfer, into a position map.
// ----------------------------------------------------------------------------
// Characters enter through a queue-style port: a transfer happens when push is
// high and full is low, with end_of_text high on the last character. Each
// field yields one result on mark_map and parse_error, shown while empty is
// low and removed by pop. The three field registers are written through
// cfg_write, cfg_index and cfg_data; the user is to write them only while
// the unit is idle, which the unit itself does not enforce. The last
// character of a field holds full high while the field is closed out in
// a finish step and then a done step. Elements are handed to a fill engine
// through a four-entry command queue. The fill engine reduces the start
// position modulo the field size one start bit at a time and then visits
// one position per cycle, up to FILL_LIMIT positions. A result is
// registered when the done command of its field leaves the queue.
// While a result waits to be popped, the unit keeps parsing and filling the
// next field; apart from the close-out cycles, full rises only when the
// command queue backs up. Reset clears all parse state, empties the result
// side and restores the register defaults.
// ----------------------------------------------------------------------------
module cron_field_mask_parser_unit #(
  parameter int MAX_POSITIONS = cfmp_pkg::MAX_POSITIONS_DEF,
  parameter int FILL_LIMIT    = cfmp_pkg::FILL_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          text_char,
  input  logic                                end_of_text,
  input  logic                                pop,
  output logic                                empty,
  output logic [cfmp_pkg::MAP_W-1:0]          mark_map,
  output logic                                parse_error,
  input  logic                                cfg_write,
  input  logic [cfmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfmp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MOD_W = $clog2(MAX_POSITIONS + 1);

  logic [cfmp_pkg::FS_W-1:0] field_size;
  logic                      value_offset;
  logic [1:0]                name_table;
  logic [MOD_W-1:0]          modulus;

  logic           q_write;
  cfmp_pkg::cmd_t q_wr_data;
  logic           q_full;
  logic           q_read;
  cfmp_pkg::cmd_t q_rd_data;
  logic           q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_size   <= cfmp_pkg::FIELD_SIZE_RST;
      value_offset <= 1'b0;
      name_table   <= cfmp_pkg::TABLE_NONE;
    end else if (cfg_write) begin
      case (cfg_index)
        cfmp_pkg::CFG_FIELD_SIZE:   field_size   <= cfg_data;
        cfmp_pkg::CFG_VALUE_OFFSET: value_offset <= cfg_data[0];
        cfmp_pkg::CFG_NAME_TABLE:   name_table   <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (field_size == '0) begin
      modulus = MOD_W'(1);
    end else if (int'(field_size) > MAX_POSITIONS) begin
      modulus = MOD_W'(MAX_POSITIONS);
    end else begin
      modulus = MOD_W'(field_size);
    end
  end

  cfmp_front #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .text_char    (text_char),
    .end_of_text  (end_of_text),
    .full         (full),
    .modulus      (modulus),
    .value_offset (value_offset),
    .name_table   (name_table),
    .q_full       (q_full),
    .q_write      (q_write),
    .q_data       (q_wr_data)
  );

  cfmp_cmd_queue #(
    .DEPTH(cfmp_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .write   (q_write),
    .wr_data (q_wr_data),
    .full    (q_full),
    .read    (q_read),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  cfmp_fill #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .FILL_LIMIT   (FILL_LIMIT)
  ) u_fill (
    .clk         (clk),
    .rst         (rst),
    .modulus     (modulus),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_read      (q_read),
    .pop         (pop),
    .empty       (empty),
    .mark_map    (mark_map),
    .parse_error (parse_error)
  );

endmodule

[hw/rtl/cfmp_cmd_queue.sv]
// ----------------------------------------------------------------------------
// cfmp_cmd_queue
// Small command queue between the character parser and the fill engine.
// ----------------------------------------------------------------------------
module cfmp_cmd_queue #(
  parameter int DEPTH = cfmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           write,
  input  cfmp_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           read,
  output cfmp_pkg::cmd_t rd_data,
  output logic           empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfmp_pkg::cmd_t   slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = write && !full;
  assign do_rd   = read && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/cfmp_front.sv]
// ----------------------------------------------------------------------------
// cfmp_front
// Character parser: classifies each character, tracks the element syntax and
// issues fill and done commands to the command queue.
// ----------------------------------------------------------------------------
module cfmp_front #(
  parameter int MAX_POSITIONS = cfmp_pkg::MAX_POSITIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [7:0]                        text_char,
  input  logic                              end_of_text,
  output logic                              full,
  input  logic [$clog2(MAX_POSITIONS+1)-1:0] modulus,
  input  logic                              value_offset,
  input  logic [1:0]                        name_table,
  input  logic                              q_full,
  output logic                              q_write,
  output cfmp_pkg::cmd_t                    q_data
);

  localparam int VAL_W = cfmp_pkg::VAL_W;
  localparam int NUM_W = cfmp_pkg::NUM_W;

  localparam logic [2:0] PH_EXPECT = 3'd0;
  localparam logic [2:0] PH_NUMBER = 3'd1;
  localparam logic [2:0] PH_NAME   = 3'd2;
  localparam logic [2:0] PH_AFTER  = 3'd3;
  localparam logic [2:0] PH_STEP   = 3'd4;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  logic [2:0]       phase, phase_next;
  logic [VAL_W-1:0] rstart, rstart_next;
  logic [VAL_W-1:0] rend, rend_next;
  logic [NUM_W-1:0] num, num_next;
  logic [NUM_W-1:0] step, step_next;
  logic [15:0]      lbuf, lbuf_next;
  logic [1:0]       lcnt, lcnt_next;
  logic             err, err_next;
  logic             finish_pend, finish_pend_next;
  logic             done_pend, done_pend_next;

  logic char_ev;
  logic end_ev;
  logic done_ev;

  assign full    = q_full || finish_pend || done_pend;
  assign char_ev = push && !full;
  assign end_ev  = finish_pend && !q_full;
  assign done_ev = done_pend && !q_full;

  always_comb begin
    logic                do_after;
    logic                do_close;
    logic [VAL_W-1:0]    cval;
    logic [7:0]          lc;
    logic                name_on;
    cfmp_pkg::name_hit_t hit;

    phase_next       = phase;
    rstart_next      = rstart;
    rend_next        = rend;
    num_next         = num;
    step_next        = step;
    lbuf_next        = lbuf;
    lcnt_next        = lcnt;
    err_next         = err;
    finish_pend_next = finish_pend;
    done_pend_next   = done_pend;
    q_write          = 1'b0;
    q_data           = '0;
    do_after         = 1'b0;
    do_close         = 1'b0;
    lc               = cfmp_pkg::to_lower(text_char);
    name_on          = (name_table == cfmp_pkg::TABLE_MONTH) ||
                       (name_table == cfmp_pkg::TABLE_DAY);
    hit              = cfmp_pkg::name_lookup(name_table, {lbuf[7:0], lbuf[15:8], lc});
    cval             = {1'b0, num} - VAL_W'(value_offset);

    if (done_ev) begin
      q_write        = 1'b1;
      q_data.kind    = cfmp_pkg::CMD_DONE;
      q_data.err     = err;
      phase_next     = PH_EXPECT;
      rstart_next    = '1;
      rend_next      = '1;
      num_next       = '0;
      step_next      = NUM_W'(1);
      lbuf_next      = '0;
      lcnt_next      = '0;
      err_next       = 1'b0;
      done_pend_next = 1'b0;
    end else if ((char_ev || end_ev) && !err) begin
      if (end_ev) begin
        case (phase)
          PH_NUMBER: begin
            if (rstart[VAL_W-1]) rstart_next = cval;
            else rend_next = cval;
            do_after = 1'b1;
          end
          PH_AFTER: begin
            do_after = 1'b1;
          end
          PH_STEP: begin
            do_close = 1'b1;
          end
          default: begin
            err_next = 1'b1;
          end
        endcase
      end else begin
        case (phase)
          PH_EXPECT: begin
            if (text_char == CH_STAR) begin
              rstart_next = '0;
              rend_next   = VAL_W'(modulus) - VAL_W'(1);
              phase_next  = PH_AFTER;
            end else if (cfmp_pkg::is_digit(text_char)) begin
              num_next   = NUM_W'(text_char - cfmp_pkg::CH_ZERO);
              phase_next = PH_NUMBER;
            end else if (name_on) begin
              lbuf_next  = {8'h00, lc};
              lcnt_next  = 2'd1;
              phase_next = PH_NAME;
            end else begin
              err_next = 1'b1;
            end
          end
          PH_NUMBER: begin
            if (cfmp_pkg::is_digit(text_char)) begin
              num_next = cfmp_pkg::sat_digit(num, text_char);
            end else begin
              if (rstart[VAL_W-1]) rstart_next = cval;
              else rend_next = cval;
              phase_next = PH_AFTER;
              do_after   = 1'b1;
            end
          end
          PH_NAME: begin
            if (lcnt == 2'd1) begin
              lbuf_next = {lc, lbuf[7:0]};
              lcnt_next = 2'd2;
            end else begin
              lcnt_next = '0;
              if (hit.found) begin
                if (rstart[VAL_W-1]) rstart_next = VAL_W'(hit.idx);
                else rend_next = VAL_W'(hit.idx);
                phase_next = PH_AFTER;
              end else begin
                err_next = 1'b1;
              end
            end
          end
          PH_AFTER: begin
            do_after = 1'b1;
          end
          default: begin
            if (cfmp_pkg::is_digit(text_char)) begin
              step_next = cfmp_pkg::sat_digit(step, text_char);
            end else begin
              do_close = 1'b1;
            end
          end
        endcase
      end

      if (do_after) begin
        if (!end_ev && text_char == CH_DASH && rend_next[VAL_W-1]) begin
          phase_next = PH_EXPECT;
        end else begin
          if (rend_next[VAL_W-1]) rend_next = rstart_next;
          if (!end_ev && text_char == CH_SLASH) begin
            step_next  = '0;
            phase_next = PH_STEP;
          end else begin
            step_next = NUM_W'(1);
            do_close  = 1'b1;
          end
        end
      end

      if (do_close) begin
        if (rstart_next[VAL_W-1]) begin
          err_next = 1'b1;
        end else begin
          q_write      = 1'b1;
          q_data.kind  = cfmp_pkg::CMD_FILL;
          q_data.start = rstart_next[NUM_W-1:0];
          q_data.stop  = rend_next[VAL_W-1] ? rstart_next[NUM_W-1:0] : rend_next[NUM_W-1:0];
          q_data.step  = step_next;
          if (!end_ev && text_char == CH_COMMA) begin
            rstart_next = '1;
            rend_next   = '1;
            step_next   = NUM_W'(1);
            phase_next  = PH_EXPECT;
          end else if (!end_ev) begin
            err_next = 1'b1;
          end
        end
      end
    end

    if (char_ev && end_of_text) begin
      finish_pend_next = 1'b1;
    end
    if (end_ev) begin
      finish_pend_next = 1'b0;
      done_pend_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_EXPECT;
      rstart      <= '1;
      rend        <= '1;
      num         <= '0;
      step        <= NUM_W'(1);
      lbuf        <= '0;
      lcnt        <= '0;
      err         <= 1'b0;
      finish_pend <= 1'b0;
      done_pend   <= 1'b0;
    end else begin
      phase       <= phase_next;
      rstart      <= rstart_next;
      rend        <= rend_next;
      num         <= num_next;
      step        <= step_next;
      lbuf        <= lbuf_next;
      lcnt        <= lcnt_next;
      err         <= err_next;
      finish_pend <= finish_pend_next;
      done_pend   <= done_pend_next;
    end
  end

endmodule

[hw/rtl/cfmp_fill.sv]
// ----------------------------------------------------------------------------
// cfmp_fill
// Fill engine: reduces the start position modulo the field size, walks the
// positions of each element one per cycle, and holds the finished result.
// ----------------------------------------------------------------------------
module cfmp_fill #(
  parameter int MAX_POSITIONS = cfmp_pkg::MAX_POSITIONS_DEF,
  parameter int FILL_LIMIT    = cfmp_pkg::FILL_LIMIT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(MAX_POSITIONS+1)-1:0] modulus,
  input  logic                               q_empty,
  input  cfmp_pkg::cmd_t                     q_data,
  output logic                               q_read,
  input  logic                               pop,
  output logic                               empty,
  output logic [cfmp_pkg::MAP_W-1:0]         mark_map,
  output logic                               parse_error
);

  localparam int POS_W = $clog2(MAX_POSITIONS);
  localparam int CNT_W = $clog2(FILL_LIMIT);
  localparam int NUM_W = cfmp_pkg::NUM_W;
  localparam int MAP_W = cfmp_pkg::MAP_W;
  localparam int BIT_W = $clog2(NUM_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]       state;
  logic [MAP_W-1:0] marks;
  logic             berr;
  logic [POS_W-1:0] pos;
  logic [NUM_W-1:0] stop;
  logic [NUM_W-1:0] step;
  logic [NUM_W-1:0] left;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] rem;
  logic [NUM_W-1:0] divd;
  logic [BIT_W-1:0] bitn;
  logic             out_valid;

  logic [POS_W:0]   rem_sh;
  logic [POS_W:0]   rem_new;
  logic [POS_W:0]   pos_inc;
  logic [POS_W:0]   mod_ext;
  logic             take_done;
  logic [MAP_W-1:0] pos_mask;

  assign empty     = !out_valid;
  assign mod_ext   = (POS_W + 1)'(modulus);
  assign rem_sh    = {rem, divd[NUM_W-1]};
  assign rem_new   = (rem_sh >= mod_ext) ? rem_sh - mod_ext : rem_sh;
  assign pos_inc   = (POS_W + 1)'(pos) + 1'b1;
  assign pos_mask  = MAP_W'(1) << pos;
  assign take_done = (q_data.kind == cfmp_pkg::CMD_DONE) && (!out_valid || pop);
  assign q_read    = (state == S_IDLE) && !q_empty &&
                     ((q_data.kind == cfmp_pkg::CMD_FILL) || take_done);

  always_ff @(posedge clk) begin
    if (q_read && q_data.kind == cfmp_pkg::CMD_FILL) begin
      stop <= q_data.stop;
      step <= q_data.step;
      divd <= q_data.start;
    end else if (state == S_MOD) begin
      divd <= {divd[NUM_W-2:0], 1'b0};
    end
    if (q_read && q_data.kind == cfmp_pkg::CMD_DONE) begin
      mark_map    <= marks;
      parse_error <= berr || q_data.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      marks     <= '0;
      berr      <= 1'b0;
      pos       <= '0;
      left      <= '0;
      cnt       <= '0;
      rem       <= '0;
      bitn      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_read && q_data.kind == cfmp_pkg::CMD_DONE) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_read) begin
            if (q_data.kind == cfmp_pkg::CMD_DONE) begin
              marks <= '0;
              berr  <= 1'b0;
            end else if (!berr) begin
              rem   <= '0;
              bitn  <= '0;
              left  <= NUM_W'(1);
              cnt   <= '0;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          rem  <= rem_new[POS_W-1:0];
          bitn <= bitn + 1'b1;
          if (bitn == BIT_W'(NUM_W - 1)) begin
            pos   <= rem_new[POS_W-1:0];
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (left == NUM_W'(1)) begin
            marks <= marks | pos_mask;
            left  <= step;
          end else if (left != '0) begin
            left <= left - 1'b1;
          end
          if (cnt == CNT_W'(FILL_LIMIT - 1)) begin
            berr  <= 1'b1;
            state <= S_IDLE;
          end else if (NUM_W'(pos) == stop) begin
            state <= S_IDLE;
          end else begin
            pos <= (pos_inc == mod_ext) ? '0 : pos_inc[POS_W-1:0];
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/cfmp_checker.sv]
// ----------------------------------------------------------------------------
// cfmp_checker
// Port-level checks for the cron field mask parser, bound to the top level.
// ----------------------------------------------------------------------------
module cfmp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       push,
  input logic                       full,
  input logic                       end_of_text,
  input logic                       pop,
  input logic                       empty,
  input logic [cfmp_pkg::MAP_W-1:0] mark_map,
  input logic                       parse_error
);

  // The result side is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  // The character side is open right after reset.
  a_open_after_reset: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked right after reset");

  // Closing a field always holds off the next character in the cycle after its last character is taken.
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (push && !full && end_of_text) |=> full)
    else $error("character taken while a field was being closed");

  // A waiting result does not change until it is popped.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(mark_map) && $stable(parse_error)))
    else $error("waiting result changed or vanished");

endmodule

bind cron_field_mask_parser_unit cfmp_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .end_of_text (end_of_text),
  .pop         (pop),
  .empty       (empty),
  .mark_map    (mark_map),
  .parse_error (parse_error)
);

[tb/cron_field_mask_parser_unit_tb.sv]
// ----------------------------------------------------------------------------
// cron_field_mask_parser_unit_tb
// Self-checking testbench for the cron field mask parser unit.
// ----------------------------------------------------------------------------
// Field text is sent one character per transfer. A predictor inside the
// testbench parses the same text under the same register settings and
// queues the expected position map and error flag for every field. Each
// result popped from the unit is checked against the oldest expectation.
// Directed fields cover stars, ranges, steps, lists, names, saturation, wrap,
// the walk limit and syntax errors. Random fields follow under several
// register settings, with random idle bursts on both sides, a long result
// hold-off that fills the unit, and a final stretch without idling.
// ----------------------------------------------------------------------------
module cron_field_mask_parser_unit_tb;

  localparam int MAP_W = cfmp_pkg::MAP_W;
  localparam int NUM_W = cfmp_pkg::NUM_W;

  typedef enum logic [2:0] {
    SCAN_ELEMENT,
    SCAN_NUMBER,
    SCAN_NAME,
    SCAN_AFTER,
    SCAN_STEP
  } scan_phase_t;

  typedef struct {
    logic [MAP_W-1:0] map;
    logic             err;
  } field_result_t;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam int SETTLE_CYCLES    = 40;

  localparam logic [23:0] MONTH_WORDS [12] = '{
    "jan", "feb", "mar", "apr", "may", "jun",
    "jul", "aug", "sep", "oct", "nov", "dec"
  };
  localparam logic [23:0] DAY_WORDS [7] = '{
    "sun", "mon", "tue", "wed", "thu", "fri", "sat"
  };

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            push = 1'b0;
  logic                            full;
  logic [7:0]                      text_char = '0;
  logic                            end_of_text = 1'b0;
  logic                            pop = 1'b0;
  logic                            empty;
  logic [MAP_W-1:0]                mark_map;
  logic                            parse_error;
  logic                            cfg_write = 1'b0;
  logic [cfmp_pkg::CFG_IDX_W-1:0]  cfg_index = cfmp_pkg::CFG_FIELD_SIZE;
  logic [cfmp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  cron_field_mask_parser_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .text_char   (text_char),
    .end_of_text (end_of_text),
    .pop         (pop),
    .empty       (empty),
    .mark_map    (mark_map),
    .parse_error (parse_error),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  logic [cfmp_pkg::FS_W-1:0] cfg_size = cfmp_pkg::FIELD_SIZE_RST;
  logic                      cfg_offset = 1'b0;
  logic [1:0]                cfg_table = cfmp_pkg::TABLE_NONE;

  logic [MAP_W-1:0] pr_marks;
  int               pr_start;
  int               pr_end;
  logic [NUM_W-1:0] pr_number;
  logic [NUM_W-1:0] pr_step;
  scan_phase_t      pr_phase;
  logic [7:0]       pr_letter0;
  logic [7:0]       pr_letter1;
  int               pr_letters;
  logic             pr_error;

  field_result_t    pending_results[$];
  logic [7:0]       field_text[$];
  int               err_count = 0;
  int               chars_sent = 0;
  int               hold_left = 0;
  bit               no_idle = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("cron_field_mask_parser_unit_tb: done, errors");
    $finish;
  end

  // Predictor of the parser.

  function automatic int wrap_size();
    int m;
    m = int'(cfg_size);
    if (m == 0) m = 1;
    if (m > cfmp_pkg::MAX_POSITIONS_DEF) m = cfmp_pkg::MAX_POSITIONS_DEF;
    return m;
  endfunction

  function automatic bit char_is_digit(logic [7:0] c);
    return (c >= cfmp_pkg::CH_ZERO) && (c <= cfmp_pkg::CH_NINE);
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [NUM_W-1:0] add_digit(logic [NUM_W-1:0] acc, logic [7:0] c);
    int v;
    v = int'(acc) * 10 + int'(c) - int'(cfmp_pkg::CH_ZERO);
    return (v > int'(cfmp_pkg::SAT_MAX)) ? cfmp_pkg::SAT_MAX : v[NUM_W-1:0];
  endfunction

  function automatic void reset_parse();
    pr_marks   = '0;
    pr_start   = -1;
    pr_end     = -1;
    pr_number  = '0;
    pr_step    = 12'd1;
    pr_phase   = SCAN_ELEMENT;
    pr_letter0 = '0;
    pr_letter1 = '0;
    pr_letters = 0;
    pr_error   = 1'b0;
  endfunction

  function automatic void commit_value(int v);
    if (pr_start < 0) pr_start = v;
    else pr_end = v;
  endfunction

  function automatic void fill_element();
    int m;
    int pos;
    int left;
    int visited;
    m = wrap_size();
    if (pr_start < 0) begin
      pr_error = 1'b1;
      return;
    end
    if (pr_end < 0) pr_end = pr_start;
    pos = pr_start % m;
    left = 1;
    visited = 0;
    while (1'b1) begin
      if (left != 0) begin
        left--;
        if (left == 0) begin
          pr_marks[pos] = 1'b1;
          left = int'(pr_step);
        end
      end
      visited++;
      if (visited >= cfmp_pkg::FILL_LIMIT_DEF) begin
        pr_error = 1'b1;
        return;
      end
      if (pos == pr_end) break;
      pos = (pos + 1) % m;
    end
  endfunction

  function automatic void close_element(bit at_end, logic [7:0] c);
    fill_element();
    if (pr_error) return;
    if (!at_end && c == CH_COMMA) begin
      pr_start = -1;
      pr_end   = -1;
      pr_step  = 12'd1;
      pr_phase = SCAN_ELEMENT;
    end else if (!at_end) begin
      pr_error = 1'b1;
    end
  endfunction

  function automatic void after_value(bit at_end, logic [7:0] c);
    if (!at_end && c == CH_DASH && pr_end < 0) begin
      pr_phase = SCAN_ELEMENT;
      return;
    end
    if (pr_end < 0) pr_end = pr_start;
    if (!at_end && c == CH_SLASH) begin
      pr_step  = '0;
      pr_phase = SCAN_STEP;
      return;
    end
    pr_step = 12'd1;
    close_element(at_end, c);
  endfunction

  function automatic void match_name(logic [7:0] third);
    logic [23:0] key;
    int          i;
    key = {pr_letter0, pr_letter1, third};
    if (cfg_table == cfmp_pkg::TABLE_MONTH) begin
      for (i = 0; i < 12; i++) begin
        if (MONTH_WORDS[i] == key) begin
          commit_value(i);
          pr_phase = SCAN_AFTER;
          return;
        end
      end
    end else begin
      for (i = 0; i < 7; i++) begin
        if (DAY_WORDS[i] == key) begin
          commit_value(i);
          pr_phase = SCAN_AFTER;
          return;
        end
      end
    end
    pr_error = 1'b1;
  endfunction

  function automatic int number_value();
    return int'(pr_number) - (cfg_offset ? 1 : 0);
  endfunction

  function automatic void scan_char(logic [7:0] c);
    case (pr_phase)
      SCAN_ELEMENT: begin
        if (c == CH_STAR) begin
          pr_start = 0;
          pr_end   = wrap_size() - 1;
          pr_phase = SCAN_AFTER;
        end else if (char_is_digit(c)) begin
          pr_number = NUM_W'(c - cfmp_pkg::CH_ZERO);
          pr_phase  = SCAN_NUMBER;
        end else if (cfg_table == cfmp_pkg::TABLE_MONTH ||
                     cfg_table == cfmp_pkg::TABLE_DAY) begin
          pr_letter0 = fold_case(c);
          pr_letters = 1;
          pr_phase   = SCAN_NAME;
        end else begin
          pr_error = 1'b1;
        end
      end
      SCAN_NUMBER: begin
        if (char_is_digit(c)) begin
          pr_number = add_digit(pr_number, c);
        end else begin
          commit_value(number_value());
          pr_phase = SCAN_AFTER;
          after_value(1'b0, c);
        end
      end
      SCAN_NAME: begin
        if (pr_letters == 1) begin
          pr_letter1 = fold_case(c);
          pr_letters = 2;
        end else begin
          pr_letters = 0;
          match_name(fold_case(c));
        end
      end
      SCAN_AFTER: after_value(1'b0, c);
      default: begin
        if (char_is_digit(c)) pr_step = add_digit(pr_step, c);
        else close_element(1'b0, c);
      end
    endcase
  endfunction

  function automatic void finish_field();
    case (pr_phase)
      SCAN_NUMBER: begin
        commit_value(number_value());
        after_value(1'b1, 8'h00);
      end
      SCAN_AFTER: after_value(1'b1, 8'h00);
      SCAN_STEP: close_element(1'b1, 8'h00);
      default: pr_error = 1'b1;
    endcase
  endfunction

  function automatic void predict_char(logic [7:0] c, bit last);
    field_result_t res;
    if (!pr_error) scan_char(c);
    if (last) begin
      if (!pr_error) finish_field();
      res.map = pr_marks;
      res.err = pr_error;
      pending_results.push_back(res);
      reset_parse();
    end
  endfunction

  // Result side: random pop bursts, the long hold-off, and the checks.

  initial begin : result_monitor
    field_result_t exp_res;
    int            gap;
    int            spell;
    bit            busy;
    gap = 0;
    spell = 0;
    busy = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) begin
            $display("unexpected result: mark_map %h parse_error %b", mark_map, parse_error);
          end
        end else begin
          exp_res = pending_results.pop_front();
          if (mark_map !== exp_res.map || parse_error !== exp_res.err) begin
            err_count++;
            if (err_count <= 10) begin
              $display("mismatch: mark_map exp %h got %h, parse_error exp %b got %b",
                       exp_res.map, mark_map, exp_res.err, parse_error);
            end
          end
        end
      end
      if (spell == 0) begin
        spell = $urandom_range(40, 300);
        busy = ($urandom_range(0, 1) == 1);
      end
      spell--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!no_idle && busy && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(0, 9);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Character side.

  task automatic send_char(logic [7:0] c, bit last);
    push <= 1'b1;
    text_char <= c;
    end_of_text <= last;
    do @(posedge clk); while (full);
    predict_char(c, last);
    chars_sent++;
  endtask

  task automatic idle_sender(int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_field();
    int n;
    bit busy;
    n = field_text.size();
    busy = ($urandom_range(0, 1) == 1);
    for (int i = 0; i < n; i++) begin
      send_char(field_text[i], i == n - 1);
      if (!no_idle && busy && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 10));
    end
  endtask

  task automatic send_text(string s);
    field_text.delete();
    for (int i = 0; i < s.len(); i++) field_text.push_back(s[i]);
    send_field();
  endtask

  task automatic send_byte(logic [7:0] c);
    field_text.delete();
    field_text.push_back(c);
    send_field();
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [cfmp_pkg::CFG_DATA_W-1:0] size_data,
                           logic [cfmp_pkg::CFG_DATA_W-1:0] offset_data,
                           logic [cfmp_pkg::CFG_DATA_W-1:0] table_data);
    wait_results_done();
    cfg_write <= 1'b1;
    cfg_index <= cfmp_pkg::CFG_FIELD_SIZE;
    cfg_data <= size_data;
    @(posedge clk);
    cfg_size = size_data[cfmp_pkg::FS_W-1:0];
    cfg_index <= cfmp_pkg::CFG_VALUE_OFFSET;
    cfg_data <= offset_data;
    @(posedge clk);
    cfg_offset = offset_data[0];
    cfg_index <= cfmp_pkg::CFG_NAME_TABLE;
    cfg_data <= table_data;
    @(posedge clk);
    cfg_table = table_data[1:0];
    cfg_write <= 1'b0;
  endtask

  // Random field text.

  task automatic append_number(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) field_text.push_back(s[i]);
  endtask

  task automatic append_value();
    logic [23:0] word;
    logic [7:0]  ch;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      field_text.push_back(CH_STAR);
    end else if (pick < 5 && (cfg_table == cfmp_pkg::TABLE_MONTH ||
                              cfg_table == cfmp_pkg::TABLE_DAY)) begin
      if (cfg_table == cfmp_pkg::TABLE_MONTH) word = MONTH_WORDS[$urandom_range(0, 11)];
      else word = DAY_WORDS[$urandom_range(0, 6)];
      for (int k = 0; k < 3; k++) begin
        ch = word[23 - 8 * k -: 8];
        if ($urandom_range(0, 2) == 0) ch = ch - 8'd32;
        field_text.push_back(ch);
      end
    end else if ($urandom_range(0, 19) == 0) begin
      append_number($urandom_range(0, 99999));
    end else begin
      append_number($urandom_range(0, wrap_size()));
    end
  endtask

  task automatic compose_field();
    int elements;
    int spot;
    field_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) field_text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    elements = $urandom_range(1, 3);
    for (int e = 0; e < elements; e++) begin
      if (e > 0) field_text.push_back(CH_COMMA);
      append_value();
      if ($urandom_range(0, 9) < 4) begin
        field_text.push_back(CH_DASH);
        append_value();
      end
      if ($urandom_range(0, 9) < 3) begin
        field_text.push_back(CH_SLASH);
        if ($urandom_range(0, 4) != 0) append_number($urandom_range(1, wrap_size()));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: field_text.pop_back();
        1: begin
          spot = $urandom_range(0, field_text.size() - 1);
          field_text[spot] = 8'($urandom_range(0, 255));
        end
        default: field_text.push_back($urandom_range(0, 1) ? CH_DASH : CH_COMMA);
      endcase
    end
    if (field_text.size() == 0) field_text.push_back(8'($urandom_range(0, 255)));
  endtask

  // Tests.

  task automatic test_default_field();
    send_text("*");
    send_text("0-59");
    send_text("59");
    send_text("*/15");
    send_text("10-5");
    send_text("1,2,3");
    send_text("4095");
    send_text("99999-3");
    send_text("5/");
    send_text("5/-1");
    send_text("3-7/2");
    send_text("0-59/4095");
    send_text("5-*");
    send_text("*,*");
    send_text("-");
    send_text("1-");
    send_text("1,");
    send_text("a");
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_month_field();
    configure(6'd12, 6'd1, 6'(cfmp_pkg::TABLE_MONTH));
    send_text("jan-dec");
    send_text("JAN");
    send_text("Feb,mAr");
    send_text("0");
    send_text("1-12");
    send_text("13");
    send_text("jax");
    send_text("ja");
    send_text("nov-feb/2");
    send_text("dec-1");
  endtask

  task automatic test_weekday_field();
    configure(6'd7, 6'd0, 6'(cfmp_pkg::TABLE_DAY));
    send_text("sun-sat");
    send_text("MON-fri/2");
    send_text("fri-mon");
    send_text("7");
    send_text("tues");
    send_text("0-6/3");
  endtask

  task automatic test_size_extremes();
    configure(6'd0, 6'd1, 6'd3);
    send_text("*");
    send_text("1");
    send_text("0");
    send_text("x");
    configure(6'd63, 6'd0, 6'(cfmp_pkg::TABLE_NONE));
    send_text("*");
    send_text("62");
    send_text("0-59/7");
    configure(6'd1, 6'd0, 6'(cfmp_pkg::TABLE_DAY));
    send_text("*");
    send_text("sun");
    send_text("mon");
  endtask

  task automatic test_backpressure();
    configure(6'd60, 6'd0, 6'(cfmp_pkg::TABLE_NONE));
    hold_left = 400;
    repeat (24) begin
      field_text.delete();
      field_text.push_back(8'(cfmp_pkg::CH_ZERO + $urandom_range(0, 9)));
      field_text.push_back(CH_COMMA);
      field_text.push_back(CH_STAR);
      send_field();
    end
    wait_results_done();
  endtask

  task automatic test_random_fields(int phases, int chars_per_phase);
    logic [cfmp_pkg::CFG_DATA_W-1:0] size_data;
    int                              target;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 7))
        0: size_data = 6'd0;
        1: size_data = 6'd1;
        2: size_data = 6'd63;
        3: size_data = 6'd60;
        default: size_data = 6'($urandom_range(1, 63));
      endcase
      configure(size_data, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      target = chars_sent + chars_per_phase;
      while (chars_sent < target) begin
        compose_field();
        send_field();
      end
    end
  endtask

  initial begin
    reset_parse();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_field();
    test_month_field();
    test_weekday_field();
    test_size_extremes();
    test_backpressure();
    test_random_fields(5, 60);
    no_idle = 1'b1;
    test_random_fields(1, 60);
    wait_results_done();
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("cron_field_mask_parser_unit_tb: done, clean");
    end else begin
      $display("cron_field_mask_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
